// ----- hw/rtl/a2p_pkg.sv -----
// ----------------------------------------------------------------------------
// a2p_pkg: shared types and constants of the atan2 polynomial block
// Fixed-point formats, polynomial coefficients and the Q16 product rounding.
// ----------------------------------------------------------------------------
`default_nettype none

package a2p_pkg;

  // Ratio fraction bits and the quotient width (the ratio reaches 1.0).
  localparam int RatioFrac = 16;
  localparam int QW        = RatioFrac + 1;
  // Width of the signed Q16 polynomial datapath.
  localparam int PW        = 20;
  // Width of the signed Q32 reflection datapath.
  localparam int RW        = 36;
  // Number of polynomial pipeline stages.
  localparam int PolyStages = 6;

  localparam logic signed [PW-1:0] Coef7 = 20'sd3047;
  localparam logic signed [PW-1:0] Coef5 = 20'sd10441;
  localparam logic signed [PW-1:0] Coef3 = 20'sd21471;

  localparam logic signed [RW-1:0] HalfPiQ32 = 36'sd6746518852;
  localparam logic signed [RW-1:0] PiQ32     = 36'sd13493037705;

  typedef struct packed {
    logic swap;   // |y| > |x|: reflect about pi/2
    logic cneg;   // x < 0: reflect about pi
    logic sneg;   // y < 0: negate the result
    logic zero;   // both inputs zero
  } flags_t;

  // Q16 * Q16 back to Q16, rounded to nearest with ties away from zero.
  function automatic logic signed [PW-1:0] mul_q16(input logic signed [PW-1:0] x,
                                                   input logic signed [PW-1:0] y);
    logic signed [2*PW-1:0] p;
    logic [2*PW-1:0]        m;
    logic [PW-1:0]          r;
    p = x * y;
    m = (p[2*PW-1] ? -p : p) + ((2*PW)'(1) << (RatioFrac - 1));
    r = m[RatioFrac +: PW];
    return p[2*PW-1] ? -r : r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/a2p_in_if.sv -----
// ----------------------------------------------------------------------------
// a2p_in_if: input channel of the atan2 block
// Carries one sine and cosine pair per transaction under valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface a2p_in_if #(
  parameter int IN_WIDTH = 16
);
  logic                       valid;
  logic                       ready;
  logic signed [IN_WIDTH-1:0] sine_component;
  logic signed [IN_WIDTH-1:0] cosine_component;

  modport source (output valid, output sine_component, output cosine_component,
                  input ready);
  modport sink   (input valid, input sine_component, input cosine_component,
                  output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/a2p_out_if.sv -----
// ----------------------------------------------------------------------------
// a2p_out_if: output channel of the atan2 block
// Carries one angle per transaction under valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface a2p_out_if #(
  parameter int ANGLE_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [ANGLE_WIDTH-1:0] angle;

  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/a2p_div_cell.sv -----
// ----------------------------------------------------------------------------
// a2p_div_cell: one restoring division cell
// Produces one quotient bit of min/max and passes the remainder onward.
// ----------------------------------------------------------------------------
`default_nettype none

module a2p_div_cell
  import a2p_pkg::*;
#(
  parameter int IN_WIDTH = 16,
  parameter bit FIRST    = 1'b0
) (
  input  wire logic                clk_i,
  input  wire logic                en_i,
  input  wire logic [IN_WIDTH-1:0] rem_i,
  input  wire logic [IN_WIDTH-2:0] mx_i,
  input  wire logic [QW-1:0]       q_i,
  input  wire flags_t              flags_i,
  output      logic [IN_WIDTH-1:0] rem_o,
  output      logic [IN_WIDTH-2:0] mx_o,
  output      logic [QW-1:0]       q_o,
  output      flags_t              flags_o
);

  logic [IN_WIDTH-1:0] trial;
  logic                ge;

  // The first cell decides the integer bit, so its remainder is not shifted.
  assign trial = FIRST ? rem_i : {rem_i[IN_WIDTH-2:0], 1'b0};
  assign ge    = trial >= {1'b0, mx_i};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o   <= ge ? trial - {1'b0, mx_i} : trial;
      mx_o    <= mx_i;
      q_o     <= {q_i[QW-2:0], ge};
      flags_o <= flags_i;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/a2p_poly.sv -----
// ----------------------------------------------------------------------------
// a2p_poly: polynomial and reflection pipeline
// Horner evaluation of the odd seventh-order polynomial, then the pi/2 and
// pi reflections in Q32.
// ----------------------------------------------------------------------------
`default_nettype none

module a2p_poly
  import a2p_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire logic [QW-1:0]        a_i,
  input  wire flags_t               flags_i,
  output      logic signed [RW-1:0] r_o,
  output      flags_t               flags_o
);

  logic signed [PW-1:0] a_q [PolyStages-1];
  flags_t               f_q [PolyStages-1];
  logic signed [PW-1:0] sv_q [PolyStages-2];
  logic signed [PW-1:0] t_q  [PolyStages-1];
  logic signed [PW-1:0] r16;
  logic signed [RW-1:0] rq, rh, rp;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q[0]  <= PW'(a_i);
      f_q[0]  <= flags_i;
      sv_q[0] <= mul_q16(PW'(a_i), PW'(a_i));
      t_q[0]  <= '0;
      for (int i = 1; i < PolyStages - 1; i++) begin
        a_q[i] <= a_q[i-1];
        f_q[i] <= f_q[i-1];
      end
      for (int i = 1; i < PolyStages - 2; i++) begin
        sv_q[i] <= sv_q[i-1];
      end
      t_q[1] <= mul_q16(-Coef7, sv_q[0]) + Coef5;
      t_q[2] <= mul_q16(t_q[1], sv_q[1]) - Coef3;
      t_q[3] <= mul_q16(t_q[2], sv_q[2]);
      t_q[4] <= mul_q16(t_q[3], a_q[3]);
      r_o     <= (rp < 0) ? '0 : rp;
      flags_o <= f_q[4];
    end
  end

  // A polynomial that rounds below zero is clamped before the reflections.
  assign r16 = (t_q[4] + a_q[4] < 0) ? '0 : t_q[4] + a_q[4];
  assign rq  = RW'(r16) <<< (32 - RatioFrac);
  assign rh  = f_q[4].swap ? HalfPiQ32 - rq : rq;
  assign rp  = f_q[4].cneg ? PiQ32 - rh : rh;

endmodule

`default_nettype wire

// ----- hw/rtl/atan2_poly_approx.sv -----
// ----------------------------------------------------------------------------
// atan2_poly_approx: four-quadrant arctangent by an odd polynomial
// Pipeline: one input stage, 17 division cells, 6 polynomial stages and one
// output register lie between the input transaction and output valid.
// Throughput: one transaction per cycle; the whole pipeline holds only while
// a result waits at the output and the sink is not ready.
// Reset: clears the stage valid bits and the output valid; no data is reset.
// ----------------------------------------------------------------------------
`default_nettype none

module atan2_poly_approx
  import a2p_pkg::*;
#(
  parameter int IN_WIDTH        = 16,
  parameter int ANGLE_FRAC_BITS = 13
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  a2p_in_if.sink   in_i,
  a2p_out_if.source out_o
);

  localparam int AW    = ANGLE_FRAC_BITS + 3;
  localparam int Sh    = 32 - ANGLE_FRAC_BITS;
  localparam int NStg  = 1 + QW + PolyStages;
  localparam logic signed [RW-1:0] PiOut = (PiQ32 + (RW'(1) << (Sh - 1))) >>> Sh;

  logic                 en;
  logic [NStg-1:0]      v_q;
  logic                 out_valid_q;
  logic signed [AW-1:0] angle_q;

  logic [IN_WIDTH-1:0] as_full, ac_full;
  logic [IN_WIDTH-2:0] as, ac;
  flags_t              f_in;

  logic [IN_WIDTH-1:0] rem_s [QW+1];
  logic [IN_WIDTH-2:0] mx_s  [QW+1];
  logic [QW-1:0]       q_s   [QW+1];
  flags_t              f_s   [QW+1];

  logic signed [RW-1:0] r_p;
  flags_t               f_p;
  logic signed [RW-1:0] mag;

  assign en         = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  // Saturating magnitudes: the most negative code maps to the largest positive.
  assign as_full = in_i.sine_component[IN_WIDTH-1] ? -in_i.sine_component
                                                   : in_i.sine_component;
  assign ac_full = in_i.cosine_component[IN_WIDTH-1] ? -in_i.cosine_component
                                                     : in_i.cosine_component;
  assign as = as_full[IN_WIDTH-1] ? '1 : as_full[IN_WIDTH-2:0];
  assign ac = ac_full[IN_WIDTH-1] ? '1 : ac_full[IN_WIDTH-2:0];

  always_comb begin
    f_in.swap = as > ac;
    f_in.cneg = in_i.cosine_component[IN_WIDTH-1];
    f_in.sneg = in_i.sine_component[IN_WIDTH-1];
    f_in.zero = (as == '0) && (ac == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rem_s[0] <= {1'b0, (as < ac) ? as : ac};
      mx_s[0]  <= (as < ac) ? ac : as;
      q_s[0]   <= '0;
      f_s[0]   <= f_in;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    a2p_div_cell #(
      .IN_WIDTH(IN_WIDTH),
      .FIRST   (k == 0)
    ) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .rem_i  (rem_s[k]),
      .mx_i   (mx_s[k]),
      .q_i    (q_s[k]),
      .flags_i(f_s[k]),
      .rem_o  (rem_s[k+1]),
      .mx_o   (mx_s[k+1]),
      .q_o    (q_s[k+1]),
      .flags_o(f_s[k+1])
    );
  end

  a2p_poly u_poly (
    .clk_i  (clk_i),
    .en_i   (en),
    .a_i    (q_s[QW]),
    .flags_i(f_s[QW]),
    .r_o    (r_p),
    .flags_o(f_p)
  );

  assign mag = (r_p + (RW'(1) << (Sh - 1))) >>> Sh;

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (f_p.zero) begin
        angle_q <= '0;
      end else begin
        angle_q <= f_p.sneg ? -mag[AW-1:0] : mag[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v_q         <= {v_q[NStg-2:0], in_i.valid};
      out_valid_q <= v_q[NStg-1];
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.angle = angle_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> out_valid_q && $stable(angle_q))
    else $error("output transaction dropped while stalled");

  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (RW'(angle_q) <= PiOut) && (RW'(angle_q) >= -PiOut))
    else $error("angle outside -pi..pi");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && v_q[NStg-1] |=> out_valid_q)
    else $error("pipeline result lost before the output register");

endmodule

`default_nettype wire
